/* design/assert_macros.svh */
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_SAME(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* design/mexp_pkg.sv */
// Package: word width, types and state codes for the modular exponentiation block
package mexp_pkg;
    localparam int WORD_BITS = 16;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic  valid;
        t_word a;
        t_word b;
        t_word n;
    } t_chain_in;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;
endpackage

/* design/modular_exponentiation.sv */
// Modular exponentiation top level: sequencer around a bit-serial multiply chain.
// Raises base to exponent mod the modulus register, square-and-multiply from the
// exponent MSB down. Each modular multiplication runs through a 16-cell chain; the
// base is first reduced through the chain, and a modulus of 0 or 1 gives 0 without
// using the chain. busy is high until the result
// leaves; o_done marks the single result cycle and the receiver cannot stall it.
// Modulus writes are accepted at any time but must only be made while idle.
`include "assert_macros.svh"

module modular_exponentiation (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mexp_pkg::t_word       i_base_value,
    input  mexp_pkg::t_word       i_exponent_value,
    output logic                  o_done,
    output mexp_pkg::t_word       o_power_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  mexp_pkg::t_word       i_cfg_data
);
    mexp_pkg::t_state    r_state;
    mexp_pkg::t_word     r_modulus;
    mexp_pkg::t_word     r_a;
    mexp_pkg::t_word     r_b;
    mexp_pkg::t_word     r_acc;
    mexp_pkg::t_word     r_base;
    mexp_pkg::t_word     r_exp;
    logic [mexp_pkg::CNT_BITS-1:0] r_bitcnt;
    logic                r_go;
    mexp_pkg::t_chain_in w_ctl;
    logic                w_res_valid;
    mexp_pkg::t_word     w_res;

    assign w_ctl.valid = r_go;
    assign w_ctl.a     = r_a;
    assign w_ctl.b     = r_b;
    assign w_ctl.n     = r_modulus;

    mexp_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_valid (w_res_valid),
        .o_r     (w_res)
    );

    assign busy           = (r_state != mexp_pkg::S_IDLE);
    assign o_done         = (r_state == mexp_pkg::S_DONE);
    assign o_power_result = r_acc;
    assign o_cfg_ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mexp_pkg::S_IDLE;
            r_modulus <= mexp_pkg::WORD_BITS'(1);
            r_go      <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_valid) begin
                r_modulus <= i_cfg_data;
            end
            case (r_state)
                mexp_pkg::S_IDLE: begin
                    if (start) begin
                        r_exp <= i_exponent_value;
                        if (r_modulus <= mexp_pkg::WORD_BITS'(1)) begin
                            r_acc   <= '0;
                            r_state <= mexp_pkg::S_DONE;
                        end else begin
                            r_a     <= i_base_value;
                            r_b     <= mexp_pkg::WORD_BITS'(1);
                            r_go    <= 1'b1;
                            r_state <= mexp_pkg::S_RED;
                        end
                    end
                end
                mexp_pkg::S_RED: begin
                    if (w_res_valid) begin
                        r_base   <= w_res;
                        r_a      <= mexp_pkg::WORD_BITS'(1);
                        r_b      <= mexp_pkg::WORD_BITS'(1);
                        r_bitcnt <= mexp_pkg::CNT_BITS'(mexp_pkg::WORD_BITS - 1);
                        r_go     <= 1'b1;
                        r_state  <= mexp_pkg::S_SQR;
                    end
                end
                mexp_pkg::S_SQR, mexp_pkg::S_MUL: begin
                    if (w_res_valid) begin
                        r_acc <= w_res;
                        if (r_state == mexp_pkg::S_SQR && r_exp[r_bitcnt]) begin
                            r_a     <= w_res;
                            r_b     <= r_base;
                            r_go    <= 1'b1;
                            r_state <= mexp_pkg::S_MUL;
                        end else if (r_bitcnt == '0) begin
                            r_state <= mexp_pkg::S_DONE;
                        end else begin
                            r_bitcnt <= r_bitcnt - 1'b1;
                            r_a      <= w_res;
                            r_b      <= w_res;
                            r_go     <= 1'b1;
                            r_state  <= mexp_pkg::S_SQR;
                        end
                    end
                end
                mexp_pkg::S_DONE: begin
                    r_state <= mexp_pkg::S_IDLE;
                end
                default: begin
                    r_state <= mexp_pkg::S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `ASSERT_SAME(a_result_range, o_done && r_modulus > mexp_pkg::WORD_BITS'(1),
                 o_power_result < r_modulus)
    `ASSERT_SAME(a_trivial_zero, o_done && r_modulus <= mexp_pkg::WORD_BITS'(1),
                 o_power_result == '0)
    `ASSERT_SAME(a_chain_quiet, w_res_valid, r_state != mexp_pkg::S_IDLE)
endmodule

/* design/mexp_cell.sv */
// One interleaved modular multiply step: r = (2r + bit*b) mod n
module mexp_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mexp_pkg::t_word  i_r,
    input  logic             i_bit,
    input  mexp_pkg::t_word  i_b,
    input  mexp_pkg::t_word  i_n,
    output logic             o_valid,
    output mexp_pkg::t_word  o_r
);
    logic [mexp_pkg::WORD_BITS:0] w_dbl;
    logic [mexp_pkg::WORD_BITS:0] w_dbl_red;
    logic [mexp_pkg::WORD_BITS:0] w_sum;
    logic [mexp_pkg::WORD_BITS:0] w_n_ext;
    logic                         r_valid;
    mexp_pkg::t_word              r_r;
    mexp_pkg::t_word              n_r;

    always_comb begin
        w_n_ext   = {1'b0, i_n};
        w_dbl     = {i_r, 1'b0};
        w_dbl_red = (w_dbl >= w_n_ext) ? (w_dbl - w_n_ext) : w_dbl;
        w_sum     = w_dbl_red + (i_bit ? {1'b0, i_b} : '0);
        n_r       = (w_sum >= w_n_ext) ? mexp_pkg::WORD_BITS'(w_sum - w_n_ext)
                                       : mexp_pkg::WORD_BITS'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_r <= n_r;
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
endmodule

/* design/mexp_chain.sv */
// Row of multiply cells; a product passes one cell per cycle, MSB of a first
module mexp_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mexp_pkg::t_chain_in i_ctl,
    output logic                o_valid,
    output mexp_pkg::t_word     o_r
);
    logic            w_valid [mexp_pkg::WORD_BITS+1];
    mexp_pkg::t_word w_r     [mexp_pkg::WORD_BITS+1];

    assign w_valid[0] = i_ctl.valid;
    assign w_r[0]     = '0;

    for (genvar k = 0; k < mexp_pkg::WORD_BITS; k++) begin : g_cell
        mexp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_r     (w_r[k]),
            .i_bit   (i_ctl.a[mexp_pkg::WORD_BITS-1-k]),
            .i_b     (i_ctl.b),
            .i_n     (i_ctl.n),
            .o_valid (w_valid[k+1]),
            .o_r     (w_r[k+1])
        );
    end

    assign o_valid = w_valid[mexp_pkg::WORD_BITS];
    assign o_r     = w_r[mexp_pkg::WORD_BITS];
endmodule

/* bench/tb_modular_exponentiation.sv */
// Testbench for modular_exponentiation: directed and random exponentiations checked against a predictor
`timescale 1ns / 100ps

module tb_modular_exponentiation;
    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    mexp_pkg::t_word i_base_value;
    mexp_pkg::t_word i_exponent_value;
    logic            o_done;
    mexp_pkg::t_word o_power_result;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    mexp_pkg::t_word i_cfg_data;

    mexp_pkg::t_word modulus_reg;
    mexp_pkg::t_word power_queue[$];
    int unsigned     error_count;
    int unsigned     sent_count;
    int unsigned     checked_count;

    modular_exponentiation uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_value     (i_base_value),
        .i_exponent_value (i_exponent_value),
        .o_done           (o_done),
        .o_power_result   (o_power_result),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic mexp_pkg::t_word mod_power(mexp_pkg::t_word base,
                                                  mexp_pkg::t_word expo,
                                                  mexp_pkg::t_word n);
        logic [31:0] acc;
        logic [31:0] b;
        if (n <= 1) return '0;
        b   = base % n;
        acc = 1;
        for (int i = mexp_pkg::WORD_BITS - 1; i >= 0; i--) begin
            acc = (acc * acc) % n;
            if (expo[i]) acc = (acc * b) % n;
        end
        return acc[mexp_pkg::WORD_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (power_queue.size() == 0) begin
                $display("%0t: result %0d with no expected value", $time, o_power_result);
                error_count++;
            end else begin
                if (o_power_result !== power_queue[0]) begin
                    $display("%0t: power_result expected %0d actual %0d",
                             $time, power_queue[0], o_power_result);
                    error_count++;
                end
                void'(power_queue.pop_front());
                checked_count++;
            end
        end
    end

    // start stays high after a transaction is taken; drain_results lowers it, the next call only when it waits a gap
    task automatic send_power(mexp_pkg::t_word base, mexp_pkg::t_word expo);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_base_value     <= base;
        i_exponent_value <= expo;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        power_queue.push_back(mod_power(base, expo, modulus_reg));
        sent_count++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (power_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_modulus(mexp_pkg::t_word n);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        modulus_reg = n;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_modulus();
        modulus_reg = 1;
        send_power(16'hFFFF, 16'hFFFF);
        send_power(16'd5, 16'd0);
    endtask

    task automatic test_degenerate_modulus();
        write_modulus(16'd0);
        send_power(16'd7, 16'd3);
        send_power(16'd0, 16'd0);
        write_modulus(16'd1);
        send_power(16'd123, 16'd45);
    endtask

    task automatic test_field_extremes();
        mexp_pkg::t_word mods[3] = '{16'd2, 16'd65521, 16'hFFFF};
        foreach (mods[m]) begin
            write_modulus(mods[m]);
            send_power(16'd0, 16'd0);
            send_power(16'd0, 16'd5);
            send_power(16'hFFFF, 16'd0);
            send_power(16'hFFFF, 16'hFFFF);
            send_power(16'd1, 16'hFFFF);
            send_power(16'h8000, 16'h8001);
        end
    endtask

    task automatic test_random_powers(int count);
        mexp_pkg::t_word n;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 5))
                    0:       n = mexp_pkg::t_word'($urandom_range(0, 1));
                    1:       n = mexp_pkg::t_word'($urandom_range(2, 20));
                    2:       n = 16'hFFFF;
                    default: n = mexp_pkg::t_word'($urandom_range(2, 65535));
                endcase
                write_modulus(n);
            end
            if (i == count / 2) drain_results();
            send_power(mexp_pkg::t_word'($urandom_range(0, 65535)),
                       mexp_pkg::t_word'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_base_value     <= '0;
        i_exponent_value <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= '0;
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        modulus_reg   = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_degenerate_modulus();
        test_field_extremes();
        test_random_powers(1100);
        drain_results();
        repeat (600) @(posedge i_clk);
        $display("Sent %0d transactions, checked %0d results over moduli 0 to 65535.",
                 sent_count, checked_count);
        if (error_count == 0 && power_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout");
        $display("Regression FAIL");
        $finish;
    end
endmodule
